### hdl/pwmf_pkg.sv
package pwmf_pkg;

	localparam int CHAN_W       = 8;
	localparam int RANGE_W      = 16;
	localparam int CHANNELS_DEF = 64;
	localparam int WINDOW_DEF   = 4;

	localparam logic [RANGE_W-1:0] RANGE_MAX = '1;

	typedef struct packed {
		logic [CHAN_W-1:0]  channel;
		logic [RANGE_W-1:0] reading;
	} sample_t;

	typedef struct packed {
		logic [CHAN_W-1:0]  channel_out;
		logic [RANGE_W-1:0] filtered_range;
		logic               accepted;
	} result_t;

	typedef struct packed {
		logic rd_en;
		logic wr_en;
	} hist_ctl_t;

endpackage

### hdl/pwmf_if.sv
interface pwmf_sample_if;
	import pwmf_pkg::*;

	logic    valid;
	logic    ready;
	sample_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface pwmf_result_if;
	import pwmf_pkg::*;

	logic    valid;
	logic    ready;
	result_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

### hdl/pwmf_hist_mem.sv
module pwmf_hist_mem #(
	parameter int CHANNELS = pwmf_pkg::CHANNELS_DEF,
	parameter int WINDOW   = pwmf_pkg::WINDOW_DEF,
	parameter int AW       = (CHANNELS > 1) ? $clog2(CHANNELS) : 1
) (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  pwmf_pkg::hist_ctl_t                       ctl,
	input  logic [AW-1:0]                             rd_addr,
	input  logic [AW-1:0]                             wr_addr,
	input  logic [WINDOW-1:0][pwmf_pkg::RANGE_W-1:0]  wr_row,
	output logic [WINDOW-1:0][pwmf_pkg::RANGE_W-1:0]  rd_row,
	output logic                                      rd_filled
);
	import pwmf_pkg::*;

	logic [WINDOW-1:0][RANGE_W-1:0] mem [CHANNELS];
	logic [CHANNELS-1:0]            filled_q;

	// A row that was never written reads as empty and is replaced by the maximum range.
	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			mem[wr_addr] <= wr_row;
		end
		if (ctl.rd_en) begin
			rd_row <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			filled_q  <= '0;
			rd_filled <= 1'b0;
		end else begin
			if (ctl.wr_en) begin
				filled_q[wr_addr] <= 1'b1;
			end
			if (ctl.rd_en) begin
				rd_filled <= filled_q[rd_addr];
			end
		end
	end

endmodule

### hdl/pwmf_min_unit.sv
module pwmf_min_unit #(
	parameter int WINDOW = pwmf_pkg::WINDOW_DEF
) (
	input  logic [WINDOW-1:0][pwmf_pkg::RANGE_W-1:0] mem_row,
	input  logic                                     mem_filled,
	input  logic                                     fwd_hit,
	input  logic [WINDOW-1:0][pwmf_pkg::RANGE_W-1:0] fwd_row,
	input  logic [pwmf_pkg::RANGE_W-1:0]             reading,
	output logic [WINDOW-1:0][pwmf_pkg::RANGE_W-1:0] new_row,
	output logic [pwmf_pkg::RANGE_W-1:0]             min_val
);
	import pwmf_pkg::*;

	logic [WINDOW-1:0][RANGE_W-1:0] base_row;
	logic [WINDOW-1:0][RANGE_W-1:0] tree;

	always_comb begin
		if (fwd_hit) begin
			base_row = fwd_row;
		end else if (mem_filled) begin
			base_row = mem_row;
		end else begin
			base_row = {WINDOW{RANGE_MAX}};
		end
	end

	always_comb begin
		new_row[0] = reading;
		for (int k = 1; k < WINDOW; k++) begin
			new_row[k] = base_row[k-1];
		end
	end

	// Pairwise minimum tree; the smallest value ends up in slot zero.
	always_comb begin
		tree = new_row;
		for (int s = 1; s < WINDOW; s = s * 2) begin
			for (int i = 0; i + s < WINDOW; i = i + 2 * s) begin
				if (tree[i+s] < tree[i]) begin
					tree[i] = tree[i+s];
				end
			end
		end
		min_val = tree[0];
	end

endmodule

### hdl/per_channel_window_min_filter_unit.sv
// The sample is registered in stage one together with the history read, and the result
// register loads from stage one once the output is free to take a new result.
// Throughput: one sample per cycle while the result side is not stalled; the history
// memory is read when a sample is accepted and the updated row is written as that sample
// leaves stage one, with a forwarding register covering back-to-back samples of the same channel.
// Reset clears all control state and marks every history row empty, so empty rows
// read as the maximum range at once; no clearing pass is needed.
module per_channel_window_min_filter_unit #(
	parameter int CHANNELS = pwmf_pkg::CHANNELS_DEF,
	parameter int WINDOW   = pwmf_pkg::WINDOW_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	pwmf_sample_if.sink          sample,
	pwmf_result_if.source        result
);
	import pwmf_pkg::*;

	localparam int AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam logic [CHAN_W:0] CH_LIMIT = (CHAN_W + 1)'(CHANNELS);

	hist_ctl_t                      mem_ctl;
	logic [WINDOW-1:0][RANGE_W-1:0] mem_row;
	logic                           mem_filled;
	logic [WINDOW-1:0][RANGE_W-1:0] new_row;
	logic [RANGE_W-1:0]             min_val;

	logic                           s1_vld_q;
	logic [CHAN_W-1:0]              chan_s1;
	logic [RANGE_W-1:0]             reading_s1;
	logic                           inrange_s1;

	logic                           fwd_vld_q;
	logic [AW-1:0]                  fwd_addr_q;
	logic [WINDOW-1:0][RANGE_W-1:0] fwd_row_q;
	logic                           fwd_hit;

	logic                           out_vld_q;
	result_t                        out_data_q;

	logic                           s2_free;
	logic                           s1_adv;
	logic                           in_fire;
	logic [AW-1:0]                  wr_addr;

	assign s2_free      = !out_vld_q || result.ready;
	assign s1_adv       = s1_vld_q && s2_free;
	assign sample.ready = !s1_vld_q || s2_free;
	assign in_fire      = sample.valid && sample.ready;

	assign wr_addr       = chan_s1[AW-1:0];
	assign mem_ctl.rd_en = in_fire;
	assign mem_ctl.wr_en = s1_adv && inrange_s1;
	assign fwd_hit       = fwd_vld_q && (fwd_addr_q == wr_addr);

	pwmf_hist_mem #(
		.CHANNELS (CHANNELS),
		.WINDOW   (WINDOW),
		.AW       (AW)
	) u_hist_mem (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (mem_ctl),
		.rd_addr   (sample.data.channel[AW-1:0]),
		.wr_addr   (wr_addr),
		.wr_row    (new_row),
		.rd_row    (mem_row),
		.rd_filled (mem_filled)
	);

	pwmf_min_unit #(
		.WINDOW (WINDOW)
	) u_min_unit (
		.mem_row    (mem_row),
		.mem_filled (mem_filled),
		.fwd_hit    (fwd_hit),
		.fwd_row    (fwd_row_q),
		.reading    (reading_s1),
		.new_row    (new_row),
		.min_val    (min_val)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_vld_q  <= 1'b0;
			fwd_vld_q <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			if (sample.ready) begin
				s1_vld_q <= sample.valid;
			end
			if (mem_ctl.wr_en) begin
				fwd_vld_q <= 1'b1;
			end
			if (s2_free) begin
				out_vld_q <= s1_vld_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			chan_s1    <= sample.data.channel;
			reading_s1 <= sample.data.reading;
			inrange_s1 <= ({1'b0, sample.data.channel} < CH_LIMIT);
		end
		if (mem_ctl.wr_en) begin
			fwd_addr_q <= wr_addr;
			fwd_row_q  <= new_row;
		end
		if (s1_adv) begin
			out_data_q.channel_out    <= chan_s1;
			out_data_q.filtered_range <= inrange_s1 ? min_val : '0;
			out_data_q.accepted       <= inrange_s1;
		end
	end

	assign result.valid = out_vld_q;
	assign result.data  = out_data_q;

	a_reject_zero : assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && !result.data.accepted) |-> (result.data.filtered_range == '0))
		else $error("Rejected channel produced a nonzero filtered range.");

	a_write_on_advance : assert property (@(posedge clk) disable iff (!arst_n)
		mem_ctl.wr_en |-> (s1_vld_q && s2_free && inrange_s1))
		else $error("History written without an advancing in-range sample.");

	a_min_bound : assert property (@(posedge clk) disable iff (!arst_n)
		(s1_adv && inrange_s1) |=>
		(result.valid && result.data.accepted
		 && (result.data.filtered_range <= $past(reading_s1))))
		else $error("Filtered range exceeds the newest reading.");

	a_fwd_track : assert property (@(posedge clk) disable iff (!arst_n)
		mem_ctl.wr_en |=> (fwd_vld_q && (fwd_addr_q == $past(wr_addr))))
		else $error("Forwarding register does not hold the last written row.");

endmodule

### bench/per_channel_window_min_filter_unit_tb.sv
module per_channel_window_min_filter_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import pwmf_pkg::*;

	localparam int CHANNELS    = CHANNELS_DEF;
	localparam int WINDOW      = WINDOW_DEF;
	localparam int RANDOM_ITEMS = 1750;
	localparam int MAX_GAP     = 10;
	localparam int TAIL_CYCLES = 10;

	logic clk;
	logic arst_n;

	pwmf_sample_if sample_ch ();
	pwmf_result_if result_ch ();

	per_channel_window_min_filter_unit #(
		.CHANNELS(CHANNELS),
		.WINDOW  (WINDOW)
	) dut (
		.clk   (clk),
		.arst_n(arst_n),
		.sample(sample_ch),
		.result(result_ch)
	);

	logic [RANGE_W-1:0] range_history [CHANNELS][WINDOW];

	sample_t     pending_samples[$];
	result_t     expected_minima[$];
	int unsigned error_count;
	int unsigned samples_sent;
	int unsigned minima_checked;
	int unsigned rejected_checked;
	int unsigned send_gap;
	int unsigned recv_gap;
	bit          send_calm;
	bit          recv_calm;

	function automatic result_t window_min_predict(sample_t s);
		result_t            r;
		logic [RANGE_W-1:0] lowest;
		r.channel_out    = s.channel;
		r.filtered_range = '0;
		r.accepted       = 1'b0;
		if (int'(s.channel) < CHANNELS) begin
			for (int k = WINDOW - 1; k > 0; k--) begin
				range_history[s.channel][k] = range_history[s.channel][k-1];
			end
			range_history[s.channel][0] = s.reading;
			lowest = s.reading;
			for (int k = 1; k < WINDOW; k++) begin
				if (range_history[s.channel][k] < lowest) begin
					lowest = range_history[s.channel][k];
				end
			end
			r.filtered_range = lowest;
			r.accepted       = 1'b1;
		end
		return r;
	endfunction

	function automatic int unsigned draw_gap(bit calm);
		return calm ? 0 : $urandom_range(0, MAX_GAP);
	endfunction

	task automatic report_mismatch(input string msg);
		$display("%0t ns: mismatch: %s", $realtime, msg);
		error_count++;
	endtask

	task automatic queue_sample(input int unsigned ch, input int unsigned rd);
		sample_t s;
		s.channel = ch[CHAN_W-1:0];
		s.reading = rd[RANGE_W-1:0];
		pending_samples.push_back(s);
	endtask

	function automatic int unsigned random_reading();
		int unsigned sel;
		sel = $urandom_range(0, 9);
		case (sel)
			0: begin
				return 0;
			end
			1: begin
				return RANGE_MAX;
			end
			2, 3, 4: begin
				return $urandom_range(0, 255);
			end
			default: begin
				return $urandom_range(0, 65535);
			end
		endcase
	endfunction

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		arst_n          = 1'b0;
		sample_ch.valid = 1'b0;
		sample_ch.data  = '0;
		result_ch.ready = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
	end

	always @(posedge clk or negedge arst_n) begin : sample_driver
		logic    hold;
		logic    nxt_valid;
		sample_t nxt_data;
		if (!arst_n) begin
			sample_ch.valid <= 1'b0;
			sample_ch.data  <= '0;
			send_gap        <= 0;
		end else begin
			nxt_valid = 1'b0;
			nxt_data  = sample_ch.data;
			hold      = sample_ch.valid;
			if (sample_ch.valid && sample_ch.ready) begin
				expected_minima.push_back(window_min_predict(sample_ch.data));
				samples_sent++;
				hold = 1'b0;
			end
			if (hold) begin
				nxt_valid = 1'b1;
			end else if (send_gap != 0) begin
				send_gap <= send_gap - 1;
			end else if (pending_samples.size() != 0) begin
				nxt_data  = pending_samples.pop_front();
				nxt_valid = 1'b1;
				if ($urandom_range(0, 49) == 0) begin
					send_calm = !send_calm;
				end
				send_gap <= draw_gap(send_calm);
			end
			sample_ch.valid <= nxt_valid;
			sample_ch.data  <= nxt_data;
		end
	end

	always @(posedge clk or negedge arst_n) begin : result_monitor
		result_t     want;
		result_t     got;
		int unsigned gap;
		if (!arst_n) begin
			result_ch.ready <= 1'b0;
			recv_gap        <= 0;
		end else begin
			gap = (recv_gap != 0) ? recv_gap - 1 : 0;
			if (result_ch.valid && result_ch.ready) begin
				got = result_ch.data;
				if (expected_minima.size() == 0) begin
					report_mismatch($sformatf("result ch %0d range %0h with none expected",
						got.channel_out, got.filtered_range));
				end else begin
					want = expected_minima.pop_front();
					if (got.channel_out !== want.channel_out) begin
						report_mismatch($sformatf("channel_out expected %0d got %0d",
							want.channel_out, got.channel_out));
					end
					if (got.filtered_range !== want.filtered_range) begin
						report_mismatch($sformatf("ch %0d filtered_range expected %0h got %0h",
							want.channel_out, want.filtered_range, got.filtered_range));
					end
					if (got.accepted !== want.accepted) begin
						report_mismatch($sformatf("ch %0d accepted expected %0b got %0b",
							want.channel_out, want.accepted, got.accepted));
					end
					if (want.accepted) begin
						minima_checked++;
					end else begin
						rejected_checked++;
					end
				end
				if ($urandom_range(0, 49) == 0) begin
					recv_calm = !recv_calm;
				end
				gap = draw_gap(recv_calm);
			end
			recv_gap        <= gap;
			result_ch.ready <= (gap == 0);
		end
	end

	initial begin
		int unsigned hot_base;
		int unsigned ch;
		int unsigned sel;
		error_count      = 0;
		samples_sent     = 0;
		minima_checked   = 0;
		rejected_checked = 0;
		send_calm        = 1'b0;
		recv_calm        = 1'b0;
		for (int c = 0; c < CHANNELS; c++) begin
			for (int k = 0; k < WINDOW; k++) begin
				range_history[c][k] = RANGE_MAX;
			end
		end

		queue_sample(0, RANGE_MAX);
		queue_sample(0, 1000);
		queue_sample(0, 500);
		queue_sample(0, 2000);
		queue_sample(0, 3000);
		queue_sample(0, 4000);
		queue_sample(0, 5000);
		queue_sample(0, 6000);
		queue_sample(1, 700);
		queue_sample(2, 300);
		queue_sample(1, 900);
		queue_sample(2, 100);
		queue_sample(CHANNELS - 1, 0);
		queue_sample(CHANNELS - 1, RANGE_MAX);
		queue_sample(CHANNELS - 1, 12345);
		if (CHANNELS < 256) begin
			queue_sample(CHANNELS, 16'h1234);
			queue_sample(255, RANGE_MAX);
			queue_sample(255, 0);
			queue_sample($urandom_range(CHANNELS, 255), 16'h5555);
		end
		queue_sample(CHANNELS - 1, 16'hAAAA);
		queue_sample(CHANNELS / 2, 16'h5555);
		queue_sample(CHANNELS / 2, 16'hAAAA);

		hot_base = 0;
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if ($urandom_range(0, 29) == 0) begin
				hot_base = $urandom_range(0, CHANNELS - 1);
			end
			sel = $urandom_range(0, 9);
			if (sel < 7) begin
				ch = (hot_base + $urandom_range(0, 2)) % CHANNELS;
			end else if (sel < 9 || CHANNELS >= 256) begin
				ch = $urandom_range(0, CHANNELS - 1);
			end else begin
				ch = $urandom_range(CHANNELS, 255);
			end
			queue_sample(ch, random_reading());
		end

		wait (arst_n === 1'b1);
		while (pending_samples.size() != 0 || sample_ch.valid || expected_minima.size() != 0) begin
			@(negedge clk);
		end
		repeat (TAIL_CYCLES) @(negedge clk);

		$display("Sent %0d readings across %0d channels with a window of %0d.",
			samples_sent, CHANNELS, WINDOW);
		$display("Checked %0d filtered minima and %0d rejected channel numbers, %0d errors.",
			minima_checked, rejected_checked, error_count);
		if (error_count == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

	initial begin
		#5ms;
		$display("Timed out with %0d readings pending and %0d results outstanding.",
			pending_samples.size(), expected_minima.size());
		$display("== FAIL ==");
		$finish;
	end

endmodule
